@@ hw/rtl/pwu_pkg.sv @@
// Package of the particle weight update unit: payload structs, codes,
// sizes and the sine table function. No dependencies.
package pwu_pkg;

  localparam int MAX_MARKS_DEF    = 64;
  localparam int TRIG_ENTRIES_DEF = 1024;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_OBS   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_OBS   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] REG_INV_X = 2'd0;
  localparam logic [1:0] REG_INV_Y = 2'd1;
  localparam logic [1:0] REG_LOGN  = 2'd2;

  localparam logic [23:0] INV_X_RST = 24'd364089;
  localparam logic [23:0] INV_Y_RST = 24'd364089;
  localparam logic [23:0] LOGN_RST  = 24'd37357;

  localparam logic signed [47:0] W48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] W48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] mark_x;
    logic signed [23:0] mark_y;
    logic [15:0]        mark_id;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [15:0]        pose_heading;
    logic signed [23:0] obs_x;
    logic signed [23:0] obs_y;
    logic               last_obs;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        assoc_id;
    logic signed [23:0] sense_x;
    logic signed [23:0] sense_y;
    logic signed [47:0] neg_log_weight;
    logic               particle_done;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_ROT, S_SUM, S_SCAN, S_FIN, S_TERM, S_ADD, S_SAT, S_OUT
  } state_t;

  function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [63:0] ma, mb, m;
    begin
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      m  = (ma * mb) >> 30;
      mul_q30 = (a[63] != b[63]) ? -$signed(m) : $signed(m);
    end
  endfunction

  // Q1.15 sine of a 16-bit angle, evaluated at elaboration for tables.
  function automatic logic signed [15:0] sin_q15(input logic [15:0] a);
    logic [1:0]  q;
    logic [14:0] r;
    logic signed [63:0] t, t2, acc, mag;
    begin
      q = a[15:14];
      r = {1'b0, a[13:0]};
      if (q[0]) r = 15'(15'd16384 - r);
      t   = 64'(r) <<< 16;
      t2  = mul_q30(t, t);
      acc = 64'sd172272;
      acc = -64'sd5026995 + mul_q30(acc, t2);
      acc = 64'sd85569306 + mul_q30(acc, t2);
      acc = -64'sd693598669 + mul_q30(acc, t2);
      acc = 64'sd1686629713 + mul_q30(acc, t2);
      acc = mul_q30(acc, t);
      if (acc < 0) acc = 0;
      mag = (acc + 64'sd16384) >>> 15;
      if (mag > 64'sd32767) mag = 64'sd32767;
      sin_q15 = q[1] ? 16'(-mag) : 16'(mag);
    end
  endfunction

endpackage

@@ hw/rtl/pwu_trig_rom.sv @@
// Registered sine/cosine table of the particle weight update unit.
// Depends on pwu_pkg for the table function.
module pwu_trig_rom import pwu_pkg::*; #(
  parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic [$clog2(TRIG_ENTRIES)-1:0] idx,
  output logic signed [15:0]              sin_q,
  output logic signed [15:0]              cos_q
);
  localparam int IW = $clog2(TRIG_ENTRIES);

  logic signed [15:0] sin_rom [TRIG_ENTRIES];
  logic signed [15:0] cos_rom [TRIG_ENTRIES];

  for (genvar i = 0; i < TRIG_ENTRIES; i++) begin : g_rom
    localparam logic [15:0] ANG = 16'((64'(i) * 65536) / TRIG_ENTRIES);
    assign sin_rom[i] = sin_q15(ANG);
    assign cos_rom[i] = sin_q15(16'(ANG + 16'd16384));
  end

  always_ff @(posedge clk) begin
    sin_q <= sin_rom[idx[IW-1:0]];
    cos_q <= cos_rom[idx[IW-1:0]];
  end
endmodule

@@ hw/rtl/pwu_mark_mem.sv @@
// Landmark memory: one synchronous write port and one registered read port.
// Depends on pwu_pkg.
module pwu_mark_mem import pwu_pkg::*; #(
  parameter int MAX_MARKS = MAX_MARKS_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(MAX_MARKS+1)-1:0]      waddr,
  input  logic [63:0]                         wdata,
  input  logic [$clog2(MAX_MARKS+1)-1:0]      raddr,
  output logic [63:0]                         rdata
);
  localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  logic [63:0] mem [MAX_MARKS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    rdata <= mem[raddr[AW-1:0]];
  end
endmodule

@@ hw/rtl/particle_weight_update_unit.sv @@
// Particle weight update unit: top level with APB registers and sequencer.
// Depends on pwu_pkg, pwu_trig_rom and pwu_mark_mem.
//
// The unit holds a table of up to MAX_MARKS landmarks in a synchronous memory.
// A load or clear item goes straight to the output step. An observation item
// looks up sine and cosine, rotates and translates the observation into the map
// frame, then scans the stored landmarks one per cycle through the memory read
// port, keeping the first nearest, and finally scales the squared offsets and
// adds the exponent minus the log normaliser to the running negative log weight;
// with no landmarks stored it skips the scan and the weight update. One item is
// handled at a time; the result sits in an output register and the next
// transfer is accepted only after it has been taken. The weight is cleared after
// an observation marked last. Registers: inv_two_var_x at 0x0, inv_two_var_y at
// 0x4, log_normaliser at 0x8; write only while idle.
module particle_weight_update_unit import pwu_pkg::*; #(
  parameter int MAX_MARKS    = MAX_MARKS_DEF,
  parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CW = $clog2(MAX_MARKS + 1);
  localparam int IW = $clog2(TRIG_ENTRIES);

  // Configuration registers.
  logic [23:0] inv_x, inv_y, logn;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= INV_X_RST;
      inv_y <= INV_Y_RST;
      logn  <= LOGN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_INV_X: inv_x <= pwdata[23:0];
        REG_INV_Y: inv_y <= pwdata[23:0];
        REG_LOGN:  logn  <= pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_INV_X: prdata = {8'd0, inv_x};
      REG_INV_Y: prdata = {8'd0, inv_y};
      REG_LOGN:  prdata = {{8{logn[23]}}, logn};
      default:   prdata = 32'd0;
    endcase
  end

  state_t state, state_next;
  in_item_t item;
  logic [CW-1:0] mark_count, scan;
  logic signed [47:0] weight_sum;

  // Trig lookup: index is the top bits of the heading.
  logic signed [15:0] sin_q, cos_q;
  pwu_trig_rom #(.TRIG_ENTRIES(TRIG_ENTRIES)) u_trig (
    .clk(clk), .idx(IW'((32'(item.pose_heading) * TRIG_ENTRIES) >> 16)),
    .sin_q(sin_q), .cos_q(cos_q)
  );

  // Landmark memory: x, y and id packed into one word.
  logic        mem_we;
  logic [63:0] mem_rdata;
  pwu_mark_mem #(.MAX_MARKS(MAX_MARKS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mark_count),
    .wdata({in_data.mark_x, in_data.mark_y, in_data.mark_id}),
    .raddr(scan), .rdata(mem_rdata)
  );

  logic signed [40:0] p_cx, p_sy, p_sx, p_cy;
  logic signed [23:0] sx, sy;
  logic [CW-1:0] rd_cnt;
  logic          rd_valid;
  logic [48:0]   best, qx_b, qy_b;
  logic [15:0]   best_id;
  logic          have;
  logic [48:0]   px_hi, py_hi;
  logic [47:0]   px_lo, py_lo;
  logic [47:0]   tx, ty;
  logic signed [49:0] wacc;
  logic          load_full;

  function automatic logic signed [23:0] xform(input logic signed [23:0] p,
                                               input logic signed [41:0] v);
    logic signed [42:0] r, s;
    begin
      r = 43'(v) + 43'sd16384;
      r = r >>> 15;
      s = 43'(p) + r;
      if (s > 43'sd8388607) xform = 24'sh7FFFFF;
      else if (s < -43'sd8388608) xform = 24'sh800000;
      else xform = 24'(s);
    end
  endfunction

  // The squared offset is multiplied in two halves; this recombines them,
  // drops the sixteen fraction bits and saturates.
  function automatic logic [47:0] term(input logic [48:0] hi, input logic [47:0] lo);
    logic [57:0] p;
    begin
      p = (58'(hi) << 8) + 58'(lo >> 16);
      term = (p > 58'(W48_MAX)) ? 48'(W48_MAX) : 48'(p);
    end
  endfunction

  // Candidate for the scan on the data read in the previous cycle.
  logic signed [24:0] dx, dy;
  logic [48:0] qx, qy;
  logic [49:0] dsum;
  always_comb begin
    dx   = 25'(sx) - 25'($signed(mem_rdata[63:40]));
    dy   = 25'(sy) - 25'($signed(mem_rdata[39:16]));
    qx   = 49'(dx * dx);
    qy   = 49'(dy * dy);
    dsum = 50'(qx) + 50'(qy);
  end

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign load_full = (in_data.action == ACT_LOAD) && (mark_count >= CW'(MAX_MARKS));

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_data.action == ACT_OBS) state_next = S_TRIG;
        else begin
          state_next = S_OUT;
          mem_we = (in_data.action == ACT_LOAD) && (mark_count < CW'(MAX_MARKS));
        end
      end
      S_TRIG:  state_next = S_ROT;
      S_ROT:   state_next = S_SUM;
      S_SUM:   state_next = (mark_count == '0) ? S_OUT : S_SCAN;
      S_SCAN:  if (rd_valid && rd_cnt == mark_count - CW'(1)) state_next = S_FIN;
      S_FIN:   state_next = S_TERM;
      S_TERM:  state_next = S_ADD;
      S_ADD:   state_next = S_SAT;
      S_SAT:   state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mark_count <= '0;
      weight_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          item <= in_data;
          out_data <= '{status: (load_full ? ST_FULL : ST_DONE), default: '0};
          if (in_data.action == ACT_LOAD) begin
            if (mark_count < CW'(MAX_MARKS)) mark_count <= mark_count + CW'(1);
          end else if (in_data.action == ACT_CLEAR) mark_count <= '0;
        end
        S_ROT: begin
          p_cx <= 41'(cos_q * item.obs_x);
          p_sy <= 41'(sin_q * item.obs_y);
          p_sx <= 41'(sin_q * item.obs_x);
          p_cy <= 41'(cos_q * item.obs_y);
        end
        S_SUM: begin
          sx <= xform(item.pose_x, 42'(p_cx) - 42'(p_sy));
          sy <= xform(item.pose_y, 42'(p_sx) + 42'(p_cy));
          scan <= '0;
          rd_valid <= 1'b0;
          have <= 1'b0;
        end
        S_SCAN: begin
          if (scan < mark_count) scan <= scan + CW'(1);
          rd_valid <= scan < mark_count;
          rd_cnt <= scan;
          if (rd_valid) have <= 1'b1;
          if (rd_valid && (!have || dsum < {1'b0, best})) begin
            best <= dsum[48:0] | {49{dsum[49]}};
            qx_b <= qx;
            qy_b <= qy;
            best_id <= mem_rdata[15:0];
          end
        end
        S_FIN: begin
          px_hi <= 49'(qx_b[48:24]) * 49'(inv_x);
          px_lo <= 48'(qx_b[23:0]) * 48'(inv_x);
          py_hi <= 49'(qy_b[48:24]) * 49'(inv_y);
          py_lo <= 48'(qy_b[23:0]) * 48'(inv_y);
        end
        S_TERM: begin
          tx <= term(px_hi, px_lo);
          ty <= term(py_hi, py_lo);
        end
        S_ADD: begin
          wacc <= 50'(weight_sum) - 50'($signed(logn)) +
                  ((49'(tx) + 49'(ty) > 49'(W48_MAX)) ? 50'(W48_MAX) :
                   50'(49'(tx) + 49'(ty)));
        end
        S_SAT: begin
          if (wacc > 50'(W48_MAX)) weight_sum <= W48_MAX;
          else if (wacc < 50'(W48_MIN)) weight_sum <= W48_MIN;
          else weight_sum <= 48'(wacc);
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (item.action == ACT_OBS) begin
            out_data <= '{status:         ((mark_count == '0) ? ST_EMPTY : ST_OBS),
                          assoc_id:       ((mark_count == '0) ? 16'd0 : best_id),
                          sense_x:        sx,
                          sense_y:        sy,
                          neg_log_weight: weight_sum,
                          particle_done:  item.last_obs};
            if (item.last_obs) weight_sum <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
